>>> hdl/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> hdl/cdf_pkg.sv
package cdf_pkg;

    localparam int LINE_DIGITS_DEF = 7;
    localparam int LINE_DIGITS_MAX = 10;

    // Longest expansion: space, digits, tab, four escape bytes.
    localparam int POS_W = $clog2(LINE_DIGITS_MAX + 6);
    localparam int NUM_W = $clog2(LINE_DIGITS_MAX + 1);
    localparam int PAD_W = 3;
    localparam int BODY_W = 3;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd5;

    localparam logic [7:0] ASCII_TAB    = 8'h09;
    localparam logic [7:0] ASCII_NL     = 8'h0A;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_DOLLAR = 8'h24;
    localparam logic [7:0] ASCII_DASH   = 8'h2D;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_I      = 8'h49;
    localparam logic [7:0] ASCII_M      = 8'h4D;
    localparam logic [7:0] ASCII_CARET  = 8'h5E;
    localparam logic [7:0] ASCII_DEL    = 8'h7F;
    localparam logic [7:0] HIGH_MASK    = 8'h7F;
    localparam logic [7:0] CTRL_FLIP    = 8'h40;

    typedef struct packed {
        logic show_tabs;
        logic show_ends;
        logic show_nonprinting;
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
    } cfg_t;

    // What one item expands to, minus the digit snapshot.
    typedef struct packed {
        logic                  has_num;
        logic [PAD_W-1:0]      pad_len;
        logic [NUM_W-1:0]      num_len;
        logic [BODY_W-1:0]     body_len;
        logic [3:0][7:0]       body;
    } plan_t;

endpackage

>>> hdl/cdf_decode.sv
module cdf_decode #(
    parameter int LINE_DIGITS = cdf_pkg::LINE_DIGITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cdf_pkg::cfg_t            cfg,
    input  logic [7:0]               in_byte,
    input  logic                     accept,
    output cdf_pkg::plan_t           plan,
    output logic                     plan_load,
    output logic [4*LINE_DIGITS-1:0] line_digits
);
    import cdf_pkg::*;

    localparam int DW = 4 * LINE_DIGITS;

    logic [1:0]    run_reg, run_next;
    logic          als_reg, als_next;
    logic [DW-1:0] digits_reg, digits_next;
    logic [DW-1:0] digits_inc;
    logic          drop;
    logic          any_on;
    logic          num_on;
    logic [NUM_W-1:0] n_dig;
    logic [7:0]    low7;

    // Saturating packed-decimal increment and significant digit count.
    always_comb begin
        logic carry;
        logic all_nines;
        carry = 1'b1;
        all_nines = 1'b1;
        digits_inc = digits_reg;
        n_dig = NUM_W'(1);
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (digits_reg[4*i +: 4] != 4'd9) all_nines = 1'b0;
            if (digits_reg[4*i +: 4] != 4'd0) n_dig = NUM_W'(i + 1);
            if (carry) begin
                if (digits_reg[4*i +: 4] == 4'd9) begin
                    digits_inc[4*i +: 4] = 4'd0;
                end else begin
                    digits_inc[4*i +: 4] = digits_reg[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines) digits_inc = digits_reg;
    end

    always_comb begin
        any_on = |cfg;
        num_on = cfg.number_all | cfg.number_nonblank;
        low7 = in_byte & HIGH_MASK;

        run_next = run_reg;
        drop = 1'b0;
        if (any_on && cfg.squeeze_blank) begin
            if (in_byte == ASCII_NL) begin
                run_next = (run_reg == 2'd3) ? 2'd3 : run_reg + 2'd1;
                drop = (run_next == 2'd3);
            end else begin
                run_next = 2'd0;
            end
        end

        als_next = als_reg;
        digits_next = digits_reg;
        plan.has_num = 1'b0;
        if (any_on && !drop && num_on) begin
            if (als_reg) begin
                als_next = 1'b0;
                if (!cfg.number_nonblank || in_byte != ASCII_NL) begin
                    plan.has_num = 1'b1;
                    digits_next = digits_inc;
                end
            end
            if (in_byte == ASCII_NL) als_next = 1'b1;
        end

        plan.num_len = n_dig;
        plan.pad_len = (n_dig < NUM_W'(5)) ? PAD_W'(6 - n_dig) : PAD_W'(1);

        plan.body = '0;
        if (cfg.show_nonprinting && in_byte[7]) begin
            plan.body[0] = ASCII_M;
            plan.body[1] = ASCII_DASH;
            if (low7 < ASCII_SPACE || low7 == ASCII_DEL) begin
                plan.body[2] = ASCII_CARET;
                plan.body[3] = low7 ^ CTRL_FLIP;
                plan.body_len = BODY_W'(4);
            end else begin
                plan.body[2] = low7;
                plan.body_len = BODY_W'(3);
            end
        end else if (cfg.show_tabs && in_byte == ASCII_TAB) begin
            plan.body[0] = ASCII_CARET;
            plan.body[1] = ASCII_I;
            plan.body_len = BODY_W'(2);
        end else if (cfg.show_ends && in_byte == ASCII_NL) begin
            plan.body[0] = ASCII_DOLLAR;
            plan.body[1] = ASCII_NL;
            plan.body_len = BODY_W'(2);
        end else if (cfg.show_nonprinting && in_byte != ASCII_TAB && in_byte != ASCII_NL &&
                     (in_byte < ASCII_SPACE || in_byte == ASCII_DEL)) begin
            plan.body[0] = ASCII_CARET;
            plan.body[1] = in_byte ^ CTRL_FLIP;
            plan.body_len = BODY_W'(2);
        end else begin
            plan.body[0] = in_byte;
            plan.body_len = BODY_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 2'd0;
            als_reg <= 1'b1;
            digits_reg <= DW'(1);
        end else if (accept) begin
            run_reg <= run_next;
            als_reg <= als_next;
            digits_reg <= digits_next;
        end
    end

    assign plan_load = accept && !drop;
    assign line_digits = digits_reg;

endmodule

>>> hdl/cdf_emit.sv
module cdf_emit #(
    parameter int LINE_DIGITS = cdf_pkg::LINE_DIGITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cdf_pkg::plan_t           plan,
    input  logic [4*LINE_DIGITS-1:0] digits,
    input  logic                     plan_load,
    output logic                     take_ok,
    output logic                     plan_busy,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast
);
    import cdf_pkg::*;

    localparam int DW = 4 * LINE_DIGITS;

    plan_t          plan_reg;
    logic [DW-1:0]  digits_reg;
    logic           valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic           m_tvalid_reg;
    logic [7:0]     m_tdata_reg;
    logic           m_tlast_reg;

    logic [POS_W:0] pos_w, pad_w, pad_num, prefix_len, total, body_idx;
    logic [POS_W:0] digit_idx;
    logic [3:0]     digit_sel;
    logic           out_free, cur_last, emit;
    logic [7:0]     cur_byte;

    always_comb begin
        pos_w = {1'b0, pos_reg};
        pad_w = (POS_W+1)'(plan_reg.pad_len);
        pad_num = pad_w + (POS_W+1)'(plan_reg.num_len);
        prefix_len = plan_reg.has_num ? pad_num + (POS_W+1)'(1) : '0;
        total = prefix_len + (POS_W+1)'(plan_reg.body_len);
        body_idx = pos_w - prefix_len;
        digit_idx = pad_num - (POS_W+1)'(1) - pos_w;

        digit_sel = 4'd0;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (digit_idx == (POS_W+1)'(i)) digit_sel = digits_reg[4*i +: 4];
        end

        if (plan_reg.has_num && pos_w < pad_w) begin
            cur_byte = ASCII_SPACE;
        end else if (plan_reg.has_num && pos_w < pad_num) begin
            cur_byte = ASCII_ZERO | {4'd0, digit_sel};
        end else if (plan_reg.has_num && pos_w == pad_num) begin
            cur_byte = ASCII_TAB;
        end else begin
            cur_byte = plan_reg.body[body_idx[1:0]];
        end

        out_free = !m_tvalid_reg || m_tready;
        cur_last = (pos_w == total - (POS_W+1)'(1));
        emit = valid_reg && out_free;
        take_ok = !valid_reg || (out_free && cur_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg <= '0;
        end else if (plan_load) begin
            valid_reg <= 1'b1;
            pos_reg <= '0;
        end else if (emit && cur_last) begin
            valid_reg <= 1'b0;
        end else if (emit) begin
            pos_reg <= pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (plan_load) begin
            plan_reg <= plan;
            digits_reg <= digits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= cur_last;
        end
    end

    assign plan_busy = valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

endmodule

>>> hdl/cat_text_display_filter_top.sv
// Text display filter: takes one raw byte per item on the s_ channel and
// sends the bytes to display on the m_ channel, m_tlast marking the final
// byte for each input item. Options are six one-bit registers on the cfg_
// port (0 show_tabs, 1 show_ends, 2 show_nonprinting, 3 number_all,
// 4 number_nonblank, 5 squeeze_blank); write them only while the block is
// idle. Line numbers are kept as LINE_DIGITS packed decimal digits and
// stick at all nines. The decoder works out each accepted item's expansion
// combinationally; the emitter sends its results one per cycle while m_tready
// allows, so an item that expands to k bytes holds the input until its last
// byte is sent (1 to 4 for the byte itself, plus 7 to LINE_DIGITS+2 for a
// line-number prefix). A squeezed newline makes no output. The first result
// is held in the plan register, then in the output register, before it is
// valid on m_; single-byte items stream one per cycle while m_tready is high.
`include "assert_macros.svh"

module cat_text_display_filter_top #(
    parameter int LINE_DIGITS = cdf_pkg::LINE_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_byte
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,   // last
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           cfg_data
);
    import cdf_pkg::*;

    cfg_t                    cfg_reg;
    plan_t                   plan;
    logic                    plan_load;
    logic                    plan_busy;
    logic                    take_ok;
    logic                    s_accept;
    logic [4*LINE_DIGITS-1:0] line_digits;

    // Register writes are always taken; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SHOW_TABS:       cfg_reg.show_tabs <= cfg_data;
                REG_SHOW_ENDS:       cfg_reg.show_ends <= cfg_data;
                REG_SHOW_NONPRINT:   cfg_reg.show_nonprinting <= cfg_data;
                REG_NUMBER_ALL:      cfg_reg.number_all <= cfg_data;
                REG_NUMBER_NONBLANK: cfg_reg.number_nonblank <= cfg_data;
                REG_SQUEEZE_BLANK:   cfg_reg.squeeze_blank <= cfg_data;
                default: ;
            endcase
        end
    end

    // Take a new item whenever the emitter is empty or finishing its last byte.
    assign s_tready = take_ok;
    assign s_accept = s_tvalid && s_tready;

    // Decode the byte and advance line state at acceptance.
    cdf_decode #(
        .LINE_DIGITS(LINE_DIGITS)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_byte    (s_tdata),
        .accept     (s_accept),
        .plan       (plan),
        .plan_load  (plan_load),
        .line_digits(line_digits)
    );

    // Hold the expansion and walk it out one byte per cycle while the output is not stalled.
    cdf_emit #(
        .LINE_DIGITS(LINE_DIGITS)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .plan     (plan),
        .digits   (line_digits),
        .plan_load(plan_load),
        .take_ok  (take_ok),
        .plan_busy(plan_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_AT(a_plan_after_accept, aclk, aresetn, (plan_load) |=> plan_busy, "plan not held after accept")
    `ASSERT_AT(a_count_needs_item, aclk, aresetn, !s_accept |=> $stable(line_digits), "line count moved without an item")
    `ASSERT_AT(a_passthru_keeps_count, aclk, aresetn, (s_accept && cfg_reg == '0) |=> $stable(line_digits), "line count moved with all options off")
    `ASSERT_NEVER(a_ready_on_stall, aclk, aresetn, plan_busy && s_tready && m_tvalid && !m_tready, "input ready while output stalled")

endmodule

>>> tb/cdf_display_checker.sv
`timescale 1ns / 100ps

// Watch the option writes, the text bytes and the displayed bytes; predict
// the display of each accepted text byte and compare it with what comes out.
module cdf_display_checker #(
    parameter int LINE_DIGITS = cdf_pkg::LINE_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           cfg_data,
    input  logic                           run_done,
    output int                             fail_count,
    output int                             outstanding
);
    import cdf_pkg::*;

    localparam int NUMBER_FIELD = 6;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } shown_byte_t;

    shown_byte_t              due_bytes[$];
    cfg_t                     opts;
    logic [1:0]               newline_run;
    logic                     at_line_start;
    logic [4*LINE_DIGITS-1:0] line_count;
    int                       mismatches = 0;
    bit                       leftovers_checked = 1'b0;

    task automatic expand_byte(input logic [7:0] ch);
        logic [7:0]  shown[$];
        logic [7:0]  low7;
        shown_byte_t entry;
        int          n;
        int          pad;
        bit          all_nines;
        bit          carry;
        if (opts == '0) begin
            entry.out_byte = ch;
            entry.last     = 1'b1;
            due_bytes.push_back(entry);
            return;
        end
        if (opts.squeeze_blank) begin
            if (ch == ASCII_NL) begin
                if (newline_run != 2'd3)
                    newline_run = newline_run + 2'd1;
                // drop the third newline in a row and every one after it
                if (newline_run > 2'd2)
                    return;
            end else begin
                newline_run = 2'd0;
            end
        end
        if (opts.number_all || opts.number_nonblank) begin
            if (at_line_start) begin
                at_line_start = 1'b0;
                if (!opts.number_nonblank || ch != ASCII_NL) begin
                    n = 1;
                    for (int i = 0; i < LINE_DIGITS; i++)
                        if (line_count[4*i +: 4] != 4'd0)
                            n = i + 1;
                    pad = (n + 1 < NUMBER_FIELD) ? NUMBER_FIELD - n : 1;
                    repeat (pad) shown.push_back(ASCII_SPACE);
                    for (int i = n - 1; i >= 0; i--)
                        shown.push_back(ASCII_ZERO + {4'd0, line_count[4*i +: 4]});
                    shown.push_back(ASCII_TAB);
                    // advance the decimal count, hold it at all nines
                    all_nines = 1'b1;
                    for (int i = 0; i < LINE_DIGITS; i++)
                        if (line_count[4*i +: 4] != 4'd9)
                            all_nines = 1'b0;
                    if (!all_nines) begin
                        carry = 1'b1;
                        for (int i = 0; i < LINE_DIGITS; i++) begin
                            if (carry) begin
                                if (line_count[4*i +: 4] == 4'd9) begin
                                    line_count[4*i +: 4] = 4'd0;
                                end else begin
                                    line_count[4*i +: 4] = line_count[4*i +: 4] + 4'd1;
                                    carry = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            if (ch == ASCII_NL)
                at_line_start = 1'b1;
        end
        low7 = ch & HIGH_MASK;
        if (opts.show_nonprinting && ch[7]) begin
            shown.push_back(ASCII_M);
            shown.push_back(ASCII_DASH);
            if (low7 < ASCII_SPACE || low7 == ASCII_DEL) begin
                shown.push_back(ASCII_CARET);
                shown.push_back(low7 ^ CTRL_FLIP);
            end else begin
                shown.push_back(low7);
            end
        end else if (opts.show_tabs && ch == ASCII_TAB) begin
            shown.push_back(ASCII_CARET);
            shown.push_back(ASCII_I);
        end else if (opts.show_ends && ch == ASCII_NL) begin
            shown.push_back(ASCII_DOLLAR);
            shown.push_back(ASCII_NL);
        end else if (opts.show_nonprinting && ch != ASCII_TAB && ch != ASCII_NL &&
                     (ch < ASCII_SPACE || ch == ASCII_DEL)) begin
            shown.push_back(ASCII_CARET);
            shown.push_back(ch ^ CTRL_FLIP);
        end else begin
            shown.push_back(ch);
        end
        foreach (shown[i]) begin
            entry.out_byte = shown[i];
            entry.last     = (i == shown.size() - 1);
            due_bytes.push_back(entry);
        end
    endtask

    always @(posedge aclk) begin
        shown_byte_t head;
        if (!aresetn) begin
            due_bytes.delete();
            opts             = '0;
            newline_run      = 2'd0;
            at_line_start    = 1'b1;
            line_count       = '0;
            line_count[3:0]  = 4'd1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SHOW_TABS:       opts.show_tabs        = cfg_data;
                    REG_SHOW_ENDS:       opts.show_ends        = cfg_data;
                    REG_SHOW_NONPRINT:   opts.show_nonprinting = cfg_data;
                    REG_NUMBER_ALL:      opts.number_all       = cfg_data;
                    REG_NUMBER_NONBLANK: opts.number_nonblank  = cfg_data;
                    REG_SQUEEZE_BLANK:   opts.squeeze_blank    = cfg_data;
                    default: ;
                endcase
            end
            // compare first: a byte accepted at this edge cannot show up yet
            if (m_tvalid && m_tready) begin
                if (due_bytes.size() == 0) begin
                    $error("out_byte %02h (last %0b) arrived with nothing pending",
                           m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    head = due_bytes.pop_front();
                    if (m_tdata !== head.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", head.out_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== head.last) begin
                        $error("last: expected %0b, got %0b", head.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expand_byte(s_tdata);
            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (due_bytes.size() != 0) begin
                    $error("%0d displayed bytes never arrived", due_bytes.size());
                    mismatches += due_bytes.size();
                end
            end
        end
        fail_count  <= mismatches;
        outstanding <= due_bytes.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cdf_pkg::*;

    localparam int LINE_DIGITS   = LINE_DIGITS_DEF;
    // Cycles without any accepted item, result or register write before the run is declared hung.
    localparam int IDLE_LIMIT    = 2000;
    // Quiet cycles after the last expected byte: covers the emitter's plan
    // and output registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 15;
    // Indexes past the register list; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data  = 1'b0;
    logic                 run_done  = 1'b0;

    int fail_count;
    int outstanding;
    int tx_idle_pct      = 12;
    int rx_idle_pct      = 55;
    int items_in         = 0;
    int bytes_out        = 0;
    int settings_applied = 0;
    int quiet_cycles     = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    cat_text_display_filter_top #(
        .LINE_DIGITS(LINE_DIGITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cdf_display_checker #(
        .LINE_DIGITS(LINE_DIGITS)
    ) display_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .run_done    (run_done),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver side: stall at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Count traffic and guard against a hung block: any accepted item,
    // result or register write resets the quiet counter.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready)
            items_in <= items_in + 1;
        if (m_tvalid && m_tready)
            bytes_out <= bytes_out + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("Timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one register write and hold it until taken; leave cfg_valid high
    // so back-to-back writes never lower and raise it in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all six option registers; bit r of opt_bits goes to register r.
    task automatic apply_options(input logic [REG_SQUEEZE_BLANK:0] opt_bits);
        for (int r = REG_SHOW_TABS; r <= REG_SQUEEZE_BLANK; r++)
            write_reg(r[CFG_IDX_W-1:0], opt_bits[r]);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Offer one text byte, idling beforehand at the sender's current rate.
    // Valid stays high after acceptance so the next byte can follow at once.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending, wait until every predicted byte has arrived, then let
    // the pipeline settle so the block is idle for option writes.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Text-like bytes: mostly printable with newlines and tabs, plus
    // control, high, delete and fully random bytes.
    function automatic logic [7:0] next_text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return 8'($urandom_range(8'h7E, ASCII_SPACE));
        else if (pick < 65)
            return ASCII_NL;
        else if (pick < 72)
            return ASCII_TAB;
        else if (pick < 82)
            return 8'($urandom_range(8'h1F, 8'h00));
        else if (pick < 94)
            return 8'($urandom_range(8'hFF, 8'h80));
        else if (pick < 97)
            return ASCII_DEL;
        else
            return 8'($urandom_range(8'hFF, 8'h00));
    endfunction

    initial begin
        logic [REG_SQUEEZE_BLANK:0] opt_bits;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Options at reset (all off): bytes pass straight through, even a
        // run of newlines.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ASCII_NL);
        send_byte(ASCII_NL);
        send_byte(ASCII_NL);
        wait_drained();

        // Writes past the register list must change nothing.
        write_reg(REG_SPARE_LO, 1'b1);
        write_reg(REG_SPARE_HI, 1'b1);
        // Everything on but non-blank numbering: number prefix, ^I, $ before
        // newline, squeezed newlines (run count saturating), delete, high
        // bytes with and without ^, and a plain control byte.
        apply_options(6'b101111);
        send_byte(8'h41);
        send_byte(ASCII_TAB);
        send_byte(ASCII_NL);
        send_byte(ASCII_NL);
        send_byte(ASCII_NL);
        send_byte(ASCII_NL);
        send_byte(ASCII_DEL);
        send_byte(8'h80);
        send_byte(8'h9F);
        send_byte(8'hA0);
        send_byte(8'hFF);
        send_byte(8'h1B);
        wait_drained();

        // Non-blank numbering alone: blank lines get no number, squeeze off
        // leaves the newline run where it was.
        apply_options(6'b010000);
        send_byte(ASCII_NL);
        send_byte(ASCII_NL);
        send_byte(8'h41);
        send_byte(ASCII_NL);
        send_byte(ASCII_SPACE);
        send_byte(ASCII_NL);
        wait_drained();

        // Random text under all-on, all-off and random option sets; switch
        // the idling pattern a third of the way in and again near the end.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 12;
            end else if (phase == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == 0)
                opt_bits = '1;
            else if (phase == 1)
                opt_bits = '0;
            else
                opt_bits = 6'($urandom_range(6'h3F, 6'h00));
            apply_options(opt_bits);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Hold off once mid-stream until every byte is out.
                if (phase == 2 && i == PHASE_ITEMS / 2)
                    wait_drained();
                // Runs of blank lines exercise squeezing and numbering.
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(4, 2)) send_byte(ASCII_NL);
                else
                    send_byte(next_text_byte());
            end
            wait_drained();
        end

        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("Covered %0d text bytes and %0d displayed bytes under %0d option sets,",
                 items_in, bytes_out, settings_applied);
        $display("with idling on either side and with none.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> cat_text_display_filter_top.f
+incdir+hdl
hdl/cdf_pkg.sv
hdl/cdf_decode.sv
hdl/cdf_emit.sv
hdl/cat_text_display_filter_top.sv
tb/cdf_display_checker.sv
tb/testbench.sv
